// ===== rtl/tpd_pkg.sv =====
`timescale 1ns / 1ps

package tpd_pkg;

    // Datapath widths
    localparam int PHASE_W      = 32;
    localparam int LUT_SEGMENTS = 64;
    localparam int SEG_BITS     = 6;
    localparam int ROM_AW       = SEG_BITS + 1;
    localparam int FRAC_W       = PHASE_W - 2 - SEG_BITS;
    localparam int SINE_W       = 16;
    localparam int SINE_OUT_W   = 17;
    localparam int D_W          = 10;
    localparam int RAMP_W       = 25;
    localparam int PEAK_W       = 24;
    localparam int MOD_W        = 16;
    localparam int VOLT_W       = 25;
    localparam int MUL_W        = 25;
    localparam int PR_W         = 48;
    localparam int PR_HALF_W    = PR_W / 2;
    localparam int ACC_W        = 41;
    localparam int SUM_W        = 64;
    localparam int LANES        = 3;
    localparam int LANE_W       = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    localparam logic [RAMP_W-1:0]  RAMP_ONE   = 25'h100_0000;
    localparam logic [PHASE_W-1:0] PH_HALF    = 32'h8000_0000;
    localparam logic [PHASE_W-1:0] PH_QUARTER = 32'h4000_0000;
    localparam logic [PHASE_W-1:0] PH_120     = 32'h5555_5555;
    localparam logic [PHASE_W-1:0] PH_240     = 32'hAAAA_AAAB;
    localparam logic [ROM_AW-1:0]  ROM_TOP    = 7'd64;

    localparam logic [FRAC_W+D_W-1:0] INTERP_HALF = 34'h0_0080_0000;
    localparam logic [ACC_W-1:0]      VOLT_HALF   = 41'h040_0000_0000;
    localparam logic [ACC_W-1:0]      MOD_HALF    = 41'h000_0080_0000;

    // Register reset values
    localparam logic [PHASE_W-1:0] PHASE_INC_RST  = 32'd25769804;
    localparam logic [PEAK_W-1:0]  PEAK_RST       = 24'd133763;
    localparam logic [MOD_W-1:0]   TARGET_MOD_RST = 16'd53494;
    localparam logic [RAMP_W-1:0]  RAMP_INC_RST   = 25'd1678;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_INC,
        REG_PEAK_VOLTS,
        REG_TARGET_MOD,
        REG_RAMP_INC
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_PEAK,
        ST_LUT,
        ST_INTERP,
        ST_LO,
        ST_HI,
        ST_DONE
    } seq_state_t;

    // Quarter-wave sine, Q1.15, entry k = round(32768 * sin(k * pi / 128))
    function automatic logic [SINE_W-1:0] sine_rom(input logic [ROM_AW-1:0] k);
        logic [SINE_W-1:0] v;
        case (k)
            7'd0:  v = 16'd0;
            7'd1:  v = 16'd804;
            7'd2:  v = 16'd1608;
            7'd3:  v = 16'd2411;
            7'd4:  v = 16'd3212;
            7'd5:  v = 16'd4011;
            7'd6:  v = 16'd4808;
            7'd7:  v = 16'd5602;
            7'd8:  v = 16'd6393;
            7'd9:  v = 16'd7180;
            7'd10: v = 16'd7962;
            7'd11: v = 16'd8740;
            7'd12: v = 16'd9512;
            7'd13: v = 16'd10279;
            7'd14: v = 16'd11039;
            7'd15: v = 16'd11793;
            7'd16: v = 16'd12540;
            7'd17: v = 16'd13279;
            7'd18: v = 16'd14010;
            7'd19: v = 16'd14733;
            7'd20: v = 16'd15447;
            7'd21: v = 16'd16151;
            7'd22: v = 16'd16846;
            7'd23: v = 16'd17531;
            7'd24: v = 16'd18205;
            7'd25: v = 16'd18868;
            7'd26: v = 16'd19520;
            7'd27: v = 16'd20160;
            7'd28: v = 16'd20788;
            7'd29: v = 16'd21403;
            7'd30: v = 16'd22006;
            7'd31: v = 16'd22595;
            7'd32: v = 16'd23170;
            7'd33: v = 16'd23732;
            7'd34: v = 16'd24279;
            7'd35: v = 16'd24812;
            7'd36: v = 16'd25330;
            7'd37: v = 16'd25833;
            7'd38: v = 16'd26320;
            7'd39: v = 16'd26791;
            7'd40: v = 16'd27246;
            7'd41: v = 16'd27684;
            7'd42: v = 16'd28106;
            7'd43: v = 16'd28511;
            7'd44: v = 16'd28899;
            7'd45: v = 16'd29269;
            7'd46: v = 16'd29622;
            7'd47: v = 16'd29957;
            7'd48: v = 16'd30274;
            7'd49: v = 16'd30572;
            7'd50: v = 16'd30853;
            7'd51: v = 16'd31114;
            7'd52: v = 16'd31357;
            7'd53: v = 16'd31581;
            7'd54: v = 16'd31786;
            7'd55: v = 16'd31972;
            7'd56: v = 16'd32138;
            7'd57: v = 16'd32286;
            7'd58: v = 16'd32413;
            7'd59: v = 16'd32522;
            7'd60: v = 16'd32610;
            7'd61: v = 16'd32679;
            7'd62: v = 16'd32729;
            7'd63: v = 16'd32758;
            7'd64: v = 16'd32768;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/tpd_tick_if.sv =====
`timescale 1ns / 1ps

interface tpd_tick_if ();
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

// ===== rtl/tpd_result_if.sv =====
`timescale 1ns / 1ps

interface tpd_result_if import tpd_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [SINE_OUT_W-1:0] sine_u;
    logic signed [SINE_OUT_W-1:0] sine_v;
    logic signed [SINE_OUT_W-1:0] sine_w;
    logic signed [VOLT_W-1:0]     volt_cmd_u;
    logic signed [VOLT_W-1:0]     volt_cmd_v;
    logic signed [VOLT_W-1:0]     volt_cmd_w;
    logic [MOD_W-1:0]             modulation_now;
    logic [RAMP_W-1:0]            ramp_now;
    logic [PHASE_W-1:0]           phase_now;

    modport source (
        output valid, output sine_u, output sine_v, output sine_w,
        output volt_cmd_u, output volt_cmd_v, output volt_cmd_w,
        output modulation_now, output ramp_now, output phase_now,
        input ready
    );
    modport sink (
        input valid, input sine_u, input sine_v, input sine_w,
        input volt_cmd_u, input volt_cmd_v, input volt_cmd_w,
        input modulation_now, input ramp_now, input phase_now,
        output ready
    );
endinterface

// ===== rtl/three_phase_dds_sine_reference_core.sv =====
`timescale 1ns / 1ps

// Three-phase DDS sine reference with soft start. Each tick transfer advances
// the Q1.24 ramp (saturating at 1.0), looks up U, V (+240 deg) and W (+120 deg)
// sines in a 65-entry quarter-wave table with linear interpolation, scales them
// by peak voltage and ramp into Q8.16 volt commands, then advances the 32-bit
// phase. A restart tick clears phase and ramp first. One 25x25 multiplier is
// shared under a sequencer: modulation, peak*ramp, then four passes per phase
// (table, interpolation, low and high partial product). The next tick is taken
// once the result has been loaded into the output register. Configuration writes
// are taken at any time and must only be issued while no tick is in flight.
module three_phase_dds_sine_reference_core
    import tpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    tpd_tick_if.sink              tick,
    tpd_result_if.source          result
);

    seq_state_t state_reg, state_next;
    logic [LANE_W-1:0] lane_reg, lane_next;

    logic [PHASE_W-1:0] phase_inc_reg;
    logic [PEAK_W-1:0]  peak_reg;
    logic [MOD_W-1:0]   target_reg;
    logic [RAMP_W-1:0]  ramp_inc_reg;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [RAMP_W-1:0]  ramp_reg, ramp_next;
    logic               out_valid_reg, out_valid_next;

    logic [PHASE_W-1:0] ph_reg, ph_next;
    logic [PHASE_W-1:0] lane_ph_reg, lane_ph_next;
    logic [PR_W-1:0]    pr_reg, pr_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [SINE_W-1:0]  rom_a_reg, rom_a_next;
    logic [D_W-1:0]     rom_d_reg, rom_d_next;
    logic [FRAC_W-1:0]  frac_reg, frac_next;
    logic               neg_reg, neg_next;
    logic [SINE_W-1:0]  mag_reg, mag_next;
    logic [MOD_W-1:0]   mod_reg, mod_next;
    logic signed [SINE_OUT_W-1:0] sine_w_reg [LANES];
    logic signed [SINE_OUT_W-1:0] sine_w_next [LANES];
    logic signed [VOLT_W-1:0]     volt_w_reg [LANES];
    logic signed [VOLT_W-1:0]     volt_w_next [LANES];

    logic signed [SINE_OUT_W-1:0] out_sine_reg [LANES];
    logic signed [VOLT_W-1:0]     out_volt_reg [LANES];
    logic [MOD_W-1:0]   out_mod_reg;
    logic [RAMP_W-1:0]  out_ramp_reg;
    logic [PHASE_W-1:0] out_phase_reg;

    logic               accept;
    logic               out_free;
    logic               load_out;
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [2*MUL_W-1:0] mul_p;

    logic [PHASE_W-1:0] start_phase;
    logic [RAMP_W-1:0]  start_ramp;
    logic [RAMP_W:0]    ramp_sum;
    logic [RAMP_W-1:0]  ramp_step;

    logic [PHASE_W-2:0] fold_raw, folded;
    logic [ROM_AW-1:0]  rom_idx;
    logic [SINE_W-1:0]  rom_lo, rom_hi;
    logic [PHASE_W-1:0] lane_off;

    logic [FRAC_W+D_W-1:0] interp_sum;
    logic [ACC_W-1:0]      mod_sum;
    logic [SUM_W-1:0]      volt_sum;
    logic [VOLT_W-1:0]     volt_mag;

    assign accept   = tick.valid && tick.ready;
    assign out_free = !out_valid_reg || result.ready;

    // Shared multiplier
    assign mul_p = mul_a * mul_b;

    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        lane_next  = lane_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tick.valid)
                begin
                    state_next = ST_MOD;
                end
                lane_next = '0;
            end
            ST_MOD:    state_next = ST_PEAK;
            ST_PEAK:   state_next = ST_LUT;
            ST_LUT:    state_next = ST_INTERP;
            ST_INTERP: state_next = ST_LO;
            ST_LO:     state_next = ST_HI;
            ST_HI:
            begin
                if (lane_reg == LANE_W'(LANES - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_LUT;
                    lane_next  = lane_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs (handshake, multiplier operands, output load)
    always_comb
    begin
        tick.ready = 1'b0;
        load_out   = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        case (state_reg)
            ST_IDLE:   tick.ready = 1'b1;
            ST_MOD:
            begin
                mul_a = MUL_W'(target_reg);
                mul_b = ramp_reg;
            end
            ST_PEAK:
            begin
                mul_a = MUL_W'(peak_reg);
                mul_b = ramp_reg;
            end
            ST_INTERP:
            begin
                mul_a = MUL_W'(rom_d_reg);
                mul_b = MUL_W'(frac_reg);
            end
            ST_LO:
            begin
                mul_a = MUL_W'(pr_reg[PR_HALF_W-1:0]);
                mul_b = MUL_W'(mag_reg);
            end
            ST_HI:
            begin
                mul_a = MUL_W'(pr_reg[PR_W-1:PR_HALF_W]);
                mul_b = MUL_W'(mag_reg);
            end
            ST_DONE:   load_out = out_free;
            default:   ;
        endcase
    end

    // Tick start: restart, ramp advance with saturation
    always_comb
    begin
        start_phase = tick.restart ? '0 : phase_reg;
        start_ramp  = tick.restart ? '0 : ramp_reg;
        ramp_sum    = {1'b0, start_ramp} + {1'b0, ramp_inc_reg};
        if (start_ramp >= RAMP_ONE)
        begin
            ramp_step = start_ramp;
        end
        else if (ramp_sum > {1'b0, RAMP_ONE})
        begin
            ramp_step = RAMP_ONE;
        end
        else
        begin
            ramp_step = ramp_sum[RAMP_W-1:0];
        end
    end

    // Fold into the first quadrant; 90 degrees exactly lands on the top entry
    always_comb
    begin
        fold_raw = lane_ph_reg[PHASE_W-2:0];
        if (fold_raw > PH_QUARTER[PHASE_W-2:0])
        begin
            folded = (PHASE_W-1)'(PH_HALF - {1'b0, fold_raw});
        end
        else
        begin
            folded = fold_raw;
        end
        rom_idx = folded[PHASE_W-2:FRAC_W];
        rom_lo  = sine_rom(rom_idx);
        rom_hi  = sine_rom(rom_idx + 1'b1);
    end

    // Offset of the next lane: V after U, W after V
    always_comb
    begin
        case (lane_reg)
            2'd0:    lane_off = PH_240;
            default: lane_off = PH_120;
        endcase
    end

    assign interp_sum = mul_p[FRAC_W+D_W-1:0] + INTERP_HALF;
    assign mod_sum    = mul_p[ACC_W-1:0] + MOD_HALF;
    assign volt_sum   = SUM_W'(acc_reg) + {mul_p[ACC_W-2:0], {PR_HALF_W{1'b0}}};
    assign volt_mag   = volt_sum[SUM_W-1:SUM_W-VOLT_W];

    // Datapath next values
    always_comb
    begin
        phase_next   = phase_reg;
        ramp_next    = ramp_reg;
        ph_next      = ph_reg;
        lane_ph_next = lane_ph_reg;
        pr_next      = pr_reg;
        acc_next     = acc_reg;
        rom_a_next   = rom_a_reg;
        rom_d_next   = rom_d_reg;
        frac_next    = frac_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;
        mod_next     = mod_reg;
        sine_w_next  = sine_w_reg;
        volt_w_next  = volt_w_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ph_next    = start_phase;
                    phase_next = start_phase + phase_inc_reg;
                    ramp_next  = ramp_step;
                end
            end
            ST_MOD:
            begin
                mod_next = mod_sum[ACC_W-2:ACC_W-1-MOD_W];
            end
            ST_PEAK:
            begin
                pr_next      = mul_p[PR_W-1:0];
                lane_ph_next = ph_reg;
            end
            ST_LUT:
            begin
                rom_a_next = rom_lo;
                // top entry has no successor
                if (rom_idx == ROM_TOP || rom_hi < rom_lo)
                begin
                    rom_d_next = '0;
                end
                else
                begin
                    rom_d_next = D_W'(rom_hi - rom_lo);
                end
                frac_next = folded[FRAC_W-1:0];
                neg_next  = lane_ph_reg[PHASE_W-1];
            end
            ST_INTERP:
            begin
                mag_next = rom_a_reg + SINE_W'(interp_sum[FRAC_W+D_W-1:FRAC_W]);
                sine_w_next[lane_reg] = neg_reg ? -$signed({1'b0, mag_next})
                                                : $signed({1'b0, mag_next});
            end
            ST_LO:
            begin
                acc_next = mul_p[ACC_W-1:0] + VOLT_HALF;
            end
            ST_HI:
            begin
                volt_w_next[lane_reg] = neg_reg ? -$signed(volt_mag) : $signed(volt_mag);
                lane_ph_next = ph_reg + lane_off;
            end
            default: ;
        endcase
    end

    assign out_valid_next = load_out || (out_valid_reg && !result.ready);

    // Control state and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lane_reg      <= '0;
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
            ramp_reg      <= '0;
            phase_inc_reg <= PHASE_INC_RST;
            peak_reg      <= PEAK_RST;
            target_reg    <= TARGET_MOD_RST;
            ramp_inc_reg  <= RAMP_INC_RST;
        end
        else
        begin
            state_reg     <= state_next;
            lane_reg      <= lane_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            ramp_reg      <= ramp_next;
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_PHASE_INC:  phase_inc_reg <= cfg_data[PHASE_W-1:0];
                    REG_PEAK_VOLTS: peak_reg      <= cfg_data[PEAK_W-1:0];
                    REG_TARGET_MOD: target_reg    <= cfg_data[MOD_W-1:0];
                    REG_RAMP_INC:   ramp_inc_reg  <= cfg_data[RAMP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Working and output payload
    always_ff @(posedge clk)
    begin
        ph_reg      <= ph_next;
        lane_ph_reg <= lane_ph_next;
        pr_reg      <= pr_next;
        acc_reg     <= acc_next;
        rom_a_reg   <= rom_a_next;
        rom_d_reg   <= rom_d_next;
        frac_reg    <= frac_next;
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        mod_reg     <= mod_next;
        sine_w_reg  <= sine_w_next;
        volt_w_reg  <= volt_w_next;
        if (load_out)
        begin
            out_sine_reg  <= sine_w_reg;
            out_volt_reg  <= volt_w_reg;
            out_mod_reg   <= mod_reg;
            out_ramp_reg  <= ramp_reg;
            out_phase_reg <= ph_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.sine_u         = out_sine_reg[0];
    assign result.sine_v         = out_sine_reg[1];
    assign result.sine_w         = out_sine_reg[2];
    assign result.volt_cmd_u     = out_volt_reg[0];
    assign result.volt_cmd_v     = out_volt_reg[1];
    assign result.volt_cmd_w     = out_volt_reg[2];
    assign result.modulation_now = out_mod_reg;
    assign result.ramp_now       = out_ramp_reg;
    assign result.phase_now      = out_phase_reg;

endmodule

// ===== sim/dds_reference_checker.sv =====
`timescale 1ns / 1ps

module dds_reference_checker
    import tpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    tpd_tick_if                   tick,
    tpd_result_if                 result,
    output int                    fail_count,
    output int                    refs_pending
);

    localparam logic [31:0] OFFS_120   = 32'h5555_5555;
    localparam logic [31:0] OFFS_240   = 32'hAAAA_AAAB;
    localparam logic [31:0] QUARTER    = 32'h4000_0000;
    localparam logic [31:0] HALF       = 32'h8000_0000;
    localparam logic [24:0] RAMP_FULL  = 25'h100_0000;
    localparam int          SEGS       = 64;

    typedef struct packed {
        logic signed [16:0] sine_u;
        logic signed [16:0] sine_v;
        logic signed [16:0] sine_w;
        logic signed [24:0] volt_u;
        logic signed [24:0] volt_v;
        logic signed [24:0] volt_w;
        logic [15:0]        modulation;
        logic [24:0]        ramp;
        logic [31:0]        phase;
    } sine_ref_t;

    logic [15:0] quarter_sine [0:SEGS];

    // mirrored registers and state
    logic [31:0] phase_inc;
    logic [23:0] peak_volts;
    logic [15:0] target_mod;
    logic [24:0] ramp_inc;
    logic [31:0] phase_acc;
    logic [24:0] ramp_lvl;

    sine_ref_t tick_refs_q [$];

    // Q30 Taylor series of sin(k*pi/128), rounded to Q1.15
    function automatic logic [15:0] quarter_sine_entry(input int k);
        longint unsigned kk;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned q;
        longint unsigned n;
        longint          acc;
        kk = k;
        x = (64'd1686629713 * kk) / 64'd64;
        x2 = (x * x) >> 30;
        term = x;
        acc = x;
        for (n = 1; n <= 12; n++)
        begin
            term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        if (acc < 0)
            acc = 0;
        q = acc;
        q = (q * 64'd32768 + 64'd536870912) >> 30;
        if (q > 64'd32768)
            q = 64'd32768;
        return q[15:0];
    endfunction

    initial
    begin
        int k;
        for (k = 0; k <= SEGS; k++)
            quarter_sine[k] = quarter_sine_entry(k);
    end

    function automatic logic [15:0] sine_magnitude(input logic [31:0] ph);
        logic [31:0] folded;
        logic [63:0] scaled;
        logic [63:0] idx;
        logic [63:0] frac;
        logic [63:0] d;
        logic [15:0] a;
        logic [15:0] b;
        folded = {1'b0, ph[30:0]};
        if (folded > QUARTER)
            folded = HALF - folded;
        scaled = {32'd0, folded} * 64'd64;
        idx = scaled >> 30;
        if (idx >= SEGS)
            return quarter_sine[SEGS];
        a = quarter_sine[idx[6:0]];
        b = quarter_sine[idx[6:0] + 7'd1];
        d = (b >= a) ? {48'd0, b - a} : 64'd0;
        frac = scaled & 64'h3FFF_FFFF;
        return a + 16'((d * frac + 64'h2000_0000) >> 30);
    endfunction

    task automatic scale_lane(input logic [31:0] ph, output logic signed [16:0] s,
                              output logic signed [24:0] v);
        logic [15:0] m;
        logic [63:0] prod;
        m = sine_magnitude(ph);
        prod = ({40'd0, peak_volts} * {39'd0, ramp_lvl} * {48'd0, m}
                + 64'h40_0000_0000) >> 39;
        if (ph[31])
        begin
            s = 17'd0 - {1'b0, m};
            v = 25'd0 - prod[24:0];
        end
        else
        begin
            s = {1'b0, m};
            v = prod[24:0];
        end
    endtask

    task automatic step_tick(input logic restart, output sine_ref_t r);
        logic [25:0] ramp_sum;
        logic [31:0] ph;
        if (restart)
        begin
            phase_acc = '0;
            ramp_lvl = '0;
        end
        if (ramp_lvl < RAMP_FULL)
        begin
            ramp_sum = {1'b0, ramp_lvl} + {1'b0, ramp_inc};
            ramp_lvl = (ramp_sum > {1'b0, RAMP_FULL}) ? RAMP_FULL : ramp_sum[24:0];
        end
        ph = phase_acc;
        scale_lane(ph, r.sine_u, r.volt_u);
        scale_lane(ph + OFFS_240, r.sine_v, r.volt_v);
        scale_lane(ph + OFFS_120, r.sine_w, r.volt_w);
        r.modulation = 16'(({48'd0, target_mod} * {39'd0, ramp_lvl} + 64'h80_0000) >> 24);
        r.ramp = ramp_lvl;
        r.phase = ph;
        phase_acc = ph + phase_inc;
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string what, input logic signed [63:0] got,
                               input logic signed [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d", what, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sine_ref_t predicted;
        sine_ref_t oldest;
        if (!rst_n)
        begin
            phase_inc = 32'd25769804;
            peak_volts = 24'd133763;
            target_mod = 16'd53494;
            ramp_inc = 25'd1678;
            phase_acc = '0;
            ramp_lvl = '0;
            tick_refs_q.delete();
            refs_pending = 0;
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PHASE_INC:  phase_inc = cfg_data;
                    REG_PEAK_VOLTS: peak_volts = cfg_data[23:0];
                    REG_TARGET_MOD: target_mod = cfg_data[15:0];
                    REG_RAMP_INC:   ramp_inc = cfg_data[24:0];
                    default: ;
                endcase
            end
            if (tick.valid && tick.ready)
            begin
                step_tick(tick.restart, predicted);
                tick_refs_q.push_back(predicted);
            end
            if (result.valid && result.ready)
            begin
                if (tick_refs_q.size() == 0)
                    report_mismatch("result transfer with no tick outstanding");
                else
                begin
                    oldest = tick_refs_q.pop_front();
                    check_field("sine_u", 64'($signed(result.sine_u)),
                                64'($signed(oldest.sine_u)));
                    check_field("sine_v", 64'($signed(result.sine_v)),
                                64'($signed(oldest.sine_v)));
                    check_field("sine_w", 64'($signed(result.sine_w)),
                                64'($signed(oldest.sine_w)));
                    check_field("volt_cmd_u", 64'($signed(result.volt_cmd_u)),
                                64'($signed(oldest.volt_u)));
                    check_field("volt_cmd_v", 64'($signed(result.volt_cmd_v)),
                                64'($signed(oldest.volt_v)));
                    check_field("volt_cmd_w", 64'($signed(result.volt_cmd_w)),
                                64'($signed(oldest.volt_w)));
                    check_field("modulation_now", 64'(result.modulation_now),
                                64'(oldest.modulation));
                    check_field("ramp_now", 64'(result.ramp_now), 64'(oldest.ramp));
                    check_field("phase_now", 64'(result.phase_now), 64'(oldest.phase));
                end
            end
            refs_pending = tick_refs_q.size();
        end
    end

endmodule

// ===== sim/tb_three_phase_dds_sine_reference_core.sv =====
`timescale 1ns / 1ps

module tb_three_phase_dds_sine_reference_core;
    import tpd_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    refs_pending;
    bit                    hold_off_req = 1'b0;
    bit                    hold_off_done = 1'b0;

    tpd_tick_if   tick_bus ();
    tpd_result_if result_bus ();

    three_phase_dds_sine_reference_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick_bus),
        .result    (result_bus)
    );

    dds_reference_checker u_ref_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .tick         (tick_bus),
        .result       (result_bus),
        .fail_count   (fail_count),
        .refs_pending (refs_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("tb_three_phase_dds_sine_reference_core failed");
        $finish;
    end

    // result side: changing stall patterns, plus one long hold-off on request
    initial
    begin
        int mode;
        int mode_left;
        int pat_len;
        int pat_cnt;
        mode = 0;
        mode_left = 0;
        pat_len = 2;
        pat_cnt = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                result_bus.ready = 1'b0;
                repeat (399) @(negedge clk);
                hold_off_done = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 200);
                    pat_len = $urandom_range(2, 7);
                end
                mode_left--;
                case (mode)
                    0: result_bus.ready = 1'b1;
                    1: result_bus.ready = 1'($urandom_range(0, 1));
                    2:
                    begin
                        result_bus.ready = (pat_cnt % pat_len) != 0;
                        pat_cnt++;
                    end
                    default: result_bus.ready = $urandom_range(0, 7) != 0;
                endcase
            end
        end
    end

    task automatic send_tick(input logic restart);
        @(negedge clk);
        tick_bus.valid = 1'b1;
        tick_bus.restart = restart;
        @(posedge clk);
        while (!tick_bus.ready)
            @(posedge clk);
    endtask

    task automatic idle_gap(input int n);
        repeat (n)
        begin
            @(negedge clk);
            tick_bus.valid = 1'b0;
            tick_bus.restart = 1'($urandom_range(0, 1));
        end
    endtask

    // registers only change with no tick in flight
    task automatic wait_idle();
        @(negedge clk);
        while (refs_pending != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
    endtask

    task automatic write_settings(input logic [31:0] inc, input logic [23:0] peak,
                                  input logic [15:0] modul, input logic [24:0] rinc);
        idle_gap(1);
        wait_idle();
        write_reg(REG_PHASE_INC, inc);
        write_reg(REG_PEAK_VOLTS, {8'd0, peak});
        write_reg(REG_TARGET_MOD, {16'd0, modul});
        write_reg(REG_RAMP_INC, {7'd0, rinc});
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic random_settings();
        logic [31:0] inc;
        logic [24:0] rinc;
        case ($urandom_range(0, 3))
            0: inc = $urandom;
            1: inc = $urandom_range(0, 1 << 20);
            2: inc = 32'h5555_5555 + $urandom_range(0, 15) - 8;
            default: inc = $urandom_range(1, 100_000_000);
        endcase
        case ($urandom_range(0, 3))
            0: rinc = 25'($urandom_range(1, 2000));
            1: rinc = 25'($urandom_range(2000, 300_000));
            2: rinc = 25'($urandom_range(1, 16777216));
            default: rinc = 25'h100_0000;
        endcase
        write_settings(inc, 24'($urandom_range(0, 24'hFF_FFFF)),
                       16'($urandom_range(0, 58982)), rinc);
    endtask

    task automatic run_phase(input int n_items, input bit idle_on, input int restart_odds,
                             input int hold_at);
        int sent;
        int burst;
        int k;
        sent = 0;
        while (sent < n_items)
        begin
            burst = $urandom_range(1, 30);
            for (k = 0; k < burst && sent < n_items; k++)
            begin
                if (sent == hold_at)
                    hold_off_req = 1'b1;
                send_tick($urandom_range(0, restart_odds) == 0);
                sent++;
            end
            if (idle_on && $urandom_range(0, 3) != 0)
                idle_gap($urandom_range(1, 20));
        end
    endtask

    initial
    begin
        int p;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_PHASE_INC;
        cfg_data = '0;
        tick_bus.valid = 1'b0;
        tick_bus.restart = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values of the registers
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);

        // quarter-turn steps hit the table top; full-scale peak and ramp
        write_settings(32'h4000_0000, 24'hFF_FFFF, 16'd58982, 25'h100_0000);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);

        // ramp sum overshoots 1.0 and saturates
        write_settings(32'hFFFF_FFFF, 24'd0, 16'd0, 25'd10_000_000);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);

        write_settings(32'h5555_5555, 24'd1, 16'd1, 25'd5_000_000);
        send_tick(1'b1);
        send_tick(1'b0);

        // zero ramp increment: ramp holds, also after a restart
        write_settings(32'd1, 24'h80_0000, 16'd32768, 25'd0);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);

        write_settings(32'hAAAA_AAAB, 24'hFF_FFFF, 16'd58982, 25'd1);
        send_tick(1'b1);
        send_tick(1'b0);

        for (p = 0; p < 8; p++)
        begin
            random_settings();
            run_phase(225, p != 0, (p % 2 == 1) ? 15 : 200, (p == 2) ? 40 : -1);
        end

        idle_gap(1);
        wait_idle();
        repeat (32) @(negedge clk);
        if (fail_count == 0 && refs_pending == 0)
            $display("tb_three_phase_dds_sine_reference_core passed");
        else
            $display("tb_three_phase_dds_sine_reference_core failed");
        $finish;
    end

endmodule
